// ----- hdl/subnet_slot_allocator_core_assert.svh -----
// Assertion macros used by the checker file of the slot allocator.
// No dependencies; take in with `include before use.
`ifndef SUBNET_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define SUBNET_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// Clocked property, disabled while reset is high.
`define SSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define SSA_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ssa_pkg.sv -----
// Shared types and constants of the subnet slot allocator.
// No dependencies; used by every module of the block but ssa_ram.
`default_nettype none

package ssa_pkg;

   localparam int WORD_W        = 32;    // bits of the busy map per memory row
   localparam int BIT_W         = 5;     // bits to select one slot inside a row
   localparam int DEF_MAX_SLOTS = 1024;
   localparam int IP_W          = 32;
   localparam int HANDLE_W      = 16;
   localparam int GRANT_W       = 10;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // Register select, taken from paddr[2]
   localparam logic REG_RANGE_START = 1'b0;
   localparam logic REG_RANGE_END   = 1'b1;

   localparam logic MODE_ACQUIRE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [HANDLE_W-1:0] slot_handle;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [GRANT_W-1:0] granted_slot;
      logic [IP_W-1:0]    local_addr;
      logic [IP_W-1:0]    remote_addr;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic row_rst;    // restart the row counter (clearing pass)
      logic clear_row;  // write zero to the current row, advance
      logic load;       // capture the request beat
      logic read;       // read the current row
      logic check;      // evaluate the row read back, update the map
      logic emit;       // load the result register
   } cmd_type;

   typedef struct packed {
      logic cfg_write;  // a register write completes this cycle
      logic clear_last; // clearing pass is at the last row
      logic fail_fast;  // request fails without touching the map
      logic scan_done;  // this check ends the item
      logic out_free;   // result register can take a beat
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/ssa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/ssa_ctrl.sv -----
// Sequencer of the slot allocator: clearing pass, request, row scan, result.
// Depends on ssa_pkg.
`default_nettype none

module ssa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire ssa_pkg::status_type status,
   output      ssa_pkg::cmd_type    cmd
);

   ssa_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (status.cfg_write) begin
         // restart the clearing pass on any register write
         cmd.row_rst = 1'b1;
         state_in    = ssa_pkg::ST_CLEAR;
      end else begin
         case (state_ff)
            ssa_pkg::ST_CLEAR: begin
               cmd.clear_row = 1'b1;
               if (status.clear_last) begin
                  state_in = ssa_pkg::ST_IDLE;
               end
            end
            ssa_pkg::ST_IDLE: begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ssa_pkg::ST_READ;
               end
            end
            ssa_pkg::ST_READ: begin
               if (status.fail_fast) begin
                  state_in = ssa_pkg::ST_EMIT;
               end else begin
                  cmd.read = 1'b1;
                  state_in = ssa_pkg::ST_SCAN;
               end
            end
            ssa_pkg::ST_SCAN: begin
               cmd.check = 1'b1;
               if (status.scan_done) begin
                  state_in = ssa_pkg::ST_EMIT;
               end
            end
            ssa_pkg::ST_EMIT: begin
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = ssa_pkg::ST_IDLE;
               end
            end
            default: begin
               state_in = ssa_pkg::ST_CLEAR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ssa_pkg::ST_IDLE) || status.cfg_write;

endmodule

`default_nettype wire

// ----- hdl/ssa_dp.sv -----
// Datapath of the slot allocator: range registers, busy map, row scan, result.
// Depends on ssa_pkg and ssa_ram.
`default_nettype none

module ssa_dp #(
   parameter int MAX_SLOTS = ssa_pkg::DEF_MAX_SLOTS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ssa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ssa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [ssa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input  wire ssa_pkg::req_type                   req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      ssa_pkg::rsp_type                   rsp_data,
   input  wire ssa_pkg::cmd_type                   cmd,
   output      ssa_pkg::status_type                status
);

   localparam int ROWS   = (MAX_SLOTS + ssa_pkg::WORD_W - 1) / ssa_pkg::WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int W      = ssa_pkg::WORD_W;

   // Configuration registers
   logic [ssa_pkg::IP_W-1:0] start_ff, end_ff;
   logic                     cfg_wr;

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == ssa_pkg::REG_RANGE_START) begin
            start_ff <= csr_pwdata;
         end else begin
            end_ff <= csr_pwdata;
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == ssa_pkg::REG_RANGE_START) ? start_ff : end_ff;

   // Pool base (in units of four addresses) and saturated slot count
   logic [29:0]      base_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [32:0]      top33, base33, diff33;
   logic [30:0]      blocks;

   always_comb begin
      top33    = {1'b0, end_ff | 32'd3} + 33'd1;
      base33   = {1'b0, start_ff & ~32'd3};
      diff33   = top33 - base33;
      blocks   = diff33[32:2];
      if (top33 <= base33) begin
         count_in = '0;
      end else if (blocks > 31'(MAX_SLOTS)) begin
         count_in = CNT_W'(MAX_SLOTS);
      end else begin
         count_in = CNT_W'(blocks);
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= start_ff[31:2];
      count_ff <= count_in;
   end

   // Request registers
   logic                         mode_ff;
   logic [ssa_pkg::HANDLE_W-1:0] handle_ff;
   logic [ROW_W-1:0]             row_ff;
   logic [SLOT_W-1:0]            slot_ff;
   logic                         ok_ff;

   // Busy map memory
   logic             wr_en, rd_en;
   logic [ROW_W-1:0] rd_addr;
   logic [W-1:0]     wr_data, rd_data;

   ssa_ram #(
      .WIDTH (W),
      .DEPTH (ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Row evaluation
   logic [31:0]             cnt32;
   logic [ROW_W-1:0]        last_row;
   logic [ssa_pkg::BIT_W-1:0] part;
   logic                    is_last, partial, is_release, in_range, hit;
   logic [W-1:0]            valid_mask, free_vec, low_vec, rel_bit;
   logic [ssa_pkg::BIT_W-1:0] free_idx;

   always_comb begin
      cnt32      = 32'(count_ff);
      last_row   = ROW_W'((cnt32 - 32'd1) >> ssa_pkg::BIT_W);
      part       = cnt32[ssa_pkg::BIT_W-1:0];
      is_last    = (row_ff == last_row);
      partial    = is_last && (part != '0);
      is_release = (mode_ff == ssa_pkg::MODE_RELEASE);
      in_range   = ({1'b0, handle_ff} < 17'(count_ff));
      for (int j = 0; j < W; j++) begin
         valid_mask[j] = !partial || (ssa_pkg::BIT_W'(j) < part);
      end
      free_vec = ~rd_data & valid_mask;
      hit      = |free_vec;
      // isolate the lowest free slot, then encode it
      low_vec  = free_vec & (~free_vec + W'(1));
      free_idx = '0;
      for (int k = 0; k < ssa_pkg::BIT_W; k++) begin
         for (int j = 0; j < W; j++) begin
            if (((j >> k) & 1) == 1) begin
               free_idx[k] = free_idx[k] | low_vec[j];
            end
         end
      end
      rel_bit = W'(1) << handle_ff[ssa_pkg::BIT_W-1:0];
   end

   // Memory port control
   always_comb begin
      wr_en   = cmd.clear_row || (cmd.check && (is_release || hit));
      if (cmd.clear_row) begin
         wr_data = '0;
      end else if (is_release) begin
         wr_data = rd_data & ~rel_bit;
      end else begin
         wr_data = rd_data | low_vec;
      end
      // during a scan, fetch the next row ahead
      rd_en   = cmd.read || (cmd.check && !is_release && !hit && !is_last);
      rd_addr = cmd.check ? row_ff + ROW_W'(1) : row_ff;
   end

   // Hold the row counter at zero through reset so the clearing pass starts at row 0
   always_ff @(posedge clock) begin
      if (reset || cmd.row_rst) begin
         row_ff <= '0;
      end else if (cmd.clear_row) begin
         row_ff <= row_ff + ROW_W'(1);
      end else if (cmd.load) begin
         mode_ff   <= req_data.mode;
         handle_ff <= req_data.slot_handle;
         ok_ff     <= 1'b0;
         slot_ff   <= '0;
         if (req_data.mode == ssa_pkg::MODE_RELEASE) begin
            row_ff <= ROW_W'(req_data.slot_handle >> ssa_pkg::BIT_W);
         end else begin
            row_ff <= '0;
         end
      end else if (cmd.check) begin
         if (is_release) begin
            ok_ff <= 1'b1;
         end else if (hit) begin
            ok_ff   <= 1'b1;
            slot_ff <= SLOT_W'({row_ff, free_idx});
         end else if (!is_last) begin
            row_ff <= row_ff + ROW_W'(1);
         end
      end
   end

   // Result register
   logic             rsp_valid_ff;
   ssa_pkg::rsp_type rsp_ff;
   logic [29:0]      blk_sum;
   logic             acq_ok;

   assign blk_sum = base_ff + 30'(slot_ff);
   assign acq_ok  = ok_ff && (mode_ff == ssa_pkg::MODE_ACQUIRE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.ok           <= ok_ff;
         rsp_ff.granted_slot <= acq_ok ? ssa_pkg::GRANT_W'(slot_ff) : '0;
         rsp_ff.local_addr   <= acq_ok ? {blk_sum, 2'b01} : '0;
         rsp_ff.remote_addr  <= acq_ok ? {blk_sum, 2'b10} : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the sequencer
   always_comb begin
      status.cfg_write  = cfg_wr;
      status.clear_last = (row_ff == ROW_W'(ROWS - 1));
      status.fail_fast  = is_release ? !in_range : (count_ff == '0);
      status.scan_done  = is_release || hit || is_last;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

// ----- hdl/subnet_slot_allocator_core.sv -----
// Slot allocator for /30 point-to-point blocks, first fit over a busy map.
// Acquire scans from row 0 (32 slots a row, one row read per cycle from the map RAM) to the
// first row with a free slot or the last row; release reads only the row of its slot; failing
// release or empty-pool acquire skips the map. One item in flight; the next beat is taken
// once it finishes. Reset (synchronous, active high) and every register write start a
// clearing pass of ceil(MAX_SLOTS/32) rows (32 at 1024 slots), during which no beat is taken.
`default_nettype none

module subnet_slot_allocator_core #(
   parameter int MAX_SLOTS = ssa_pkg::DEF_MAX_SLOTS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire ssa_pkg::req_type               req_data,
   // result channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      ssa_pkg::rsp_type               rsp_data,
   // register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ssa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ssa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [ssa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready
);

   ssa_pkg::cmd_type    cmd;
   ssa_pkg::status_type status;

   // Register port never waits
   assign csr_pready = 1'b1;

   // Sequencer: clearing pass, request capture, row scan, result hand-off
   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: range registers, busy map RAM, first-fit row evaluation, result register
   ssa_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

// ----- hdl/ssa_checker.sv -----
// Port-level checks of the slot allocator, bound to the top level.
// Depends on ssa_pkg and subnet_slot_allocator_core_assert.svh.
`default_nettype none
`include "subnet_slot_allocator_core_assert.svh"

module ssa_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire ssa_pkg::rsp_type               rsp_data,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic                           csr_pready
);

   logic cfg_wr_seen, rsp_fail, payload_zero, rsp_grant, pair_ok;

   assign cfg_wr_seen  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_fail     = rsp_valid && !rsp_data.ok;
   assign payload_zero = (rsp_data.granted_slot == '0) && (rsp_data.local_addr == '0) &&
                         (rsp_data.remote_addr == '0);
   assign rsp_grant    = rsp_valid && (rsp_data.local_addr != '0);
   assign pair_ok      = rsp_data.ok && (rsp_data.local_addr[1:0] == 2'b01) &&
                         (rsp_data.remote_addr == rsp_data.local_addr + 32'd1);

   // Hold a stalled result beat
   `SSA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "beat dropped")

   // Drop all payload on a failed beat
   `SSA_ASSERT(a_fail_zero, clock, reset, rsp_fail |-> payload_zero, "failed beat has payload")

   // Pair addresses of a grant inside one /30 block
   `SSA_ASSERT(a_pair, clock, reset, rsp_grant |-> pair_ok, "address pair malformed")

   // Stall requests while the map clears after a register write
   `SSA_ASSERT(a_cfg_clear, clock, reset, cfg_wr_seen |=> req_stall, "request taken in clear")

   // Come out of reset with no result and with requests stalled
   `SSA_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid && req_stall, "not idle after reset")

endmodule

bind subnet_slot_allocator_core ssa_checker u_ssa_checker (.*);

`default_nettype wire

// ----- test/subnet_slot_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for subnet_slot_allocator_core: predicts every result beat
// of acquires and releases over several address ranges. Needs ssa_pkg and the core.
module subnet_slot_allocator_core_tb;
   import ssa_pkg::*;

   localparam int SLOT_LIMIT  = DEF_MAX_SLOTS;
   localparam int ITEM_TARGET = 1570;     // directed + pool fill + random pools
   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 48;       // deepest scan plus a full receiver stall

   typedef enum int {
      POOL_EMPTY, POOL_SMALL, POOL_MEDIUM, POOL_TOP, POOL_SATURATED, POOL_REWRITE
   } pool_kind_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the allocator: range registers and in-use map.
   logic [31:0] cfg_start = '0;
   logic [31:0] cfg_end   = '0;
   bit          slot_busy [SLOT_LIMIT];

   rsp_type owed_outcomes [$];   // results still to come, oldest first
   int      granted_log [$];     // slots handed out since the last map clear
   int      beats_sent  = 0;
   int      mismatches  = 0;
   int      cycle_count = 0;
   bit      no_pauses   = 1'b0;  // when set, neither side idles or stalls

   subnet_slot_allocator_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abort a hung run; the limit is several times the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Shadow allocator
   // ---------------------------------------------------------------------------

   function automatic logic [31:0] pool_base();
      return cfg_start & ~32'd3;
   endfunction

   // Slot count, worked out in 33 bits so a range ending at the top of the
   // address space does not wrap, then capped at the map size.
   function automatic int unsigned pool_slots();
      logic [32:0] base;
      logic [32:0] top;
      logic [32:0] span;
      base = {1'b0, pool_base()};
      top  = {1'b0, cfg_end | 32'd3} + 33'd1;
      if (top <= base)
         return 0;
      span = (top - base) >> 2;
      return (span > SLOT_LIMIT) ? SLOT_LIMIT : int'(span);
   endfunction

   // First fit for an acquire, clear for a release; returns the result beat.
   function automatic rsp_type allocate_or_free(req_type item);
      rsp_type     reply;
      int unsigned n_slots;
      logic [31:0] block;
      reply   = '0;
      n_slots = pool_slots();
      if (item.mode == MODE_ACQUIRE) begin
         for (int s = 0; s < n_slots; s++) begin
            if (!slot_busy[s]) begin
               block              = pool_base() + (32'(s) << 2);
               slot_busy[s]       = 1'b1;
               reply.ok           = 1'b1;
               reply.granted_slot = s[GRANT_W-1:0];
               reply.local_addr   = block + 32'd1;
               reply.remote_addr  = block + 32'd2;
               break;
            end
         end
      end else if (item.slot_handle < n_slots) begin
         slot_busy[item.slot_handle] = 1'b0;
         reply.ok = 1'b1;
      end
      return reply;
   endfunction

   function automatic int pause_len();
      return no_pauses ? 0 : $urandom_range(5, 0);
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Offer one beat after a random gap and hold it until accepted. Call at a
   // falling edge; returns at the falling edge after acceptance with valid still
   // high, so a back-to-back beat keeps valid up without a glitch.
   task automatic send_request(logic mode, logic [HANDLE_W-1:0] handle);
      req_type item;
      rsp_type reply;
      int      gap;
      item.mode        = mode;
      item.slot_handle = handle;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      reply = allocate_or_free(item);
      owed_outcomes.push_back(reply);
      if (mode == MODE_ACQUIRE && reply.ok)
         granted_log.push_back(int'(reply.granted_slot));
      beats_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed result has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (owed_outcomes.size() > 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------------

   // One APB write: setup, then access until pready. psel stays up so writes can
   // run back to back; release_bus ends the transfer sequence.
   task automatic write_reg(logic sel, logic [31:0] value);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {sel, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == REG_RANGE_START)
         cfg_start = value;
      else
         cfg_end = value;
      foreach (slot_busy[s])
         slot_busy[s] = 1'b0;
      granted_log.delete();
      @(negedge clock);
      csr_penable <= 1'b0;
   endtask

   task automatic release_bus();
      csr_psel <= 1'b0;
   endtask

   // Program both range registers in random order; only while nothing is in flight.
   task automatic load_pool(logic [31:0] lo, logic [31:0] hi);
      if ($urandom_range(1, 0)) begin
         write_reg(REG_RANGE_START, lo);
         write_reg(REG_RANGE_END, hi);
      end else begin
         write_reg(REG_RANGE_END, hi);
         write_reg(REG_RANGE_START, lo);
      end
      release_bus();
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stall per beat, compare against the oldest prediction
   // ---------------------------------------------------------------------------

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin : reply_monitor
      rsp_type want;
      int      hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (owed_outcomes.size() == 0) begin
               $error("result beat with nothing pending: %p", rsp_data);
               mismatches++;
            end else begin
               want = owed_outcomes.pop_front();
               check_field("ok", 32'(want.ok), 32'(rsp_data.ok));
               check_field("granted_slot", 32'(want.granted_slot),
                           32'(rsp_data.granted_slot));
               check_field("local_addr", want.local_addr, rsp_data.local_addr);
               check_field("remote_addr", want.remote_addr, rsp_data.remote_addr);
            end
            hold = pause_len();
         end
         // Stall lands on whatever phase the core is in: scan, emit or idle.
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Random request mix
   // ---------------------------------------------------------------------------

   // Acquire with a random (ignored) handle, or release: mostly a slot handed out
   // earlier, else a slot in range, just past the top, or any 16-bit handle.
   task automatic random_request(int acquire_pct);
      int unsigned         n_slots;
      int unsigned         roll;
      int                  pick;
      logic [HANDLE_W-1:0] handle;
      n_slots = pool_slots();
      handle  = HANDLE_W'($urandom);
      if ($urandom_range(99, 0) < acquire_pct) begin
         send_request(MODE_ACQUIRE, handle);
      end else begin
         roll = $urandom_range(99, 0);
         if (roll < 60 && granted_log.size() > 0) begin
            pick   = $urandom_range(granted_log.size() - 1, 0);
            handle = HANDLE_W'(granted_log[pick]);
            granted_log.delete(pick);
         end else if (roll < 85 && n_slots > 0) begin
            handle = HANDLE_W'($urandom_range(n_slots - 1, 0));
         end else if (roll < 92) begin
            handle = HANDLE_W'(n_slots);
         end
         send_request(MODE_RELEASE, handle);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset range 0..0 is one block: one acquire fits, the next finds the pool full.
   task automatic test_reset_pool();
      send_request(MODE_ACQUIRE, 16'hFFFF);
      send_request(MODE_ACQUIRE, 16'h0000);
      send_request(MODE_RELEASE, 16'h0001);
      send_request(MODE_RELEASE, 16'hFFFF);
      send_request(MODE_RELEASE, 16'h0000);
      send_request(MODE_ACQUIRE, 16'h5A5A);
   endtask

   // End below the start's block: no slots, acquire and release both fail.
   task automatic test_empty_range();
      drain_replies();
      load_pool(32'h0000_0100, 32'h0000_00FF);
      send_request(MODE_ACQUIRE, 16'h0000);
      send_request(MODE_RELEASE, 16'h0000);
   endtask

   // Last block of the address space; the top bound is 2^32 and must not wrap.
   task automatic test_top_of_space();
      drain_replies();
      load_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_ACQUIRE, 16'h0000);
      send_request(MODE_ACQUIRE, 16'h0000);
      send_request(MODE_RELEASE, 16'h0000);
      send_request(MODE_RELEASE, 16'h0001);
   endtask

   // Whole address space: count caps at the map size; release of a free slot passes.
   task automatic test_saturated_range();
      drain_replies();
      load_pool(32'h0000_0000, 32'hFFFF_FFFF);
      send_request(MODE_ACQUIRE, 16'h0000);
      send_request(MODE_ACQUIRE, 16'h0000);
      send_request(MODE_ACQUIRE, 16'hFFFF);
      send_request(MODE_RELEASE, 16'(SLOT_LIMIT - 1));
      send_request(MODE_RELEASE, 16'(SLOT_LIMIT));
      send_request(MODE_RELEASE, 16'h0001);
      send_request(MODE_RELEASE, 16'h0001);
      send_request(MODE_ACQUIRE, 16'h0000);
      send_request(MODE_RELEASE, 16'h8000);
   endtask

   // Fill a full-size pool almost with acquires only, so the scan walks every
   // row and the map runs out near the end.
   task automatic test_pool_exhaustion();
      drain_replies();
      load_pool(32'h0A00_0002, 32'h0A00_0FFD);
      no_pauses = 1'b0;
      repeat (1060)
         random_request(99);
   endtask

   // Random ranges of every kind, each followed by a burst of random requests;
   // a quarter of the bursts run without any idling on either side.
   task automatic test_random_pools();
      pool_kind_type kind;
      logic [31:0]   lo;
      logic [31:0]   hi;
      int            n_items;
      while (beats_sent < ITEM_TARGET) begin
         drain_replies();
         kind = pool_kind_type'($urandom_range(POOL_REWRITE, POOL_EMPTY));
         lo   = $urandom;
         hi   = lo + $urandom_range(130, 0);
         n_items = $urandom_range(50, 15);
         case (kind)
            POOL_EMPTY: begin
               lo = lo | 32'h10;
               hi = $urandom_range((lo & ~32'd3) - 1, 0);
               n_items = $urandom_range(6, 2);
            end
            POOL_MEDIUM: hi = lo + $urandom_range(4200, 131);
            POOL_TOP: begin
               lo = 32'hFFFF_FFFF - $urandom_range(300, 0);
               hi = 32'hFFFF_FFFF - $urandom_range(3, 0);
            end
            POOL_SATURATED: begin
               lo = $urandom_range(32'h7FFF_FFFF, 0);
               hi = $urandom_range(1, 0) ? 32'hFFFF_FFFF
                                         : lo + 32'd4096 + $urandom_range(1 << 24, 0);
            end
            default: ;
         endcase
         // Rewriting the same start value must still clear the map.
         if (kind == POOL_REWRITE) begin
            write_reg(REG_RANGE_START, cfg_start);
            release_bus();
         end else begin
            load_pool(lo, hi);
         end
         no_pauses = ($urandom_range(3, 0) == 0);
         repeat (n_items)
            random_request(kind == POOL_SMALL ? 62 : 55);
      end
      no_pauses = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // The clearing pass after reset shows up as stall on the first beat.
      test_reset_pool();
      test_empty_range();
      test_top_of_space();
      test_saturated_range();
      test_pool_exhaustion();
      test_random_pools();
      drain_replies();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- subnet_slot_allocator_core.f -----
+incdir+hdl
hdl/ssa_pkg.sv
hdl/ssa_ram.sv
hdl/ssa_ctrl.sv
hdl/ssa_dp.sv
hdl/subnet_slot_allocator_core.sv
hdl/ssa_checker.sv
test/subnet_slot_allocator_core_tb.sv
